FILE: rtl/core/psfr_pkg.sv
// Shared types, constants and the CRC-16 byte step for the polled slave frame responder.
package psfr_pkg;

    localparam int TIMER_BITS = 20;
    localparam int TIMEOUT_W  = 20;
    localparam int NODE_W     = 4;
    localparam int STATUS_W   = 4;
    localparam int CMP_W      = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(60000);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // commands carried on the slave tuser
    localparam logic [1:0] CMD_RX_BYTE = 2'd0;
    localparam logic [1:0] CMD_MS_TICK = 2'd1;
    localparam logic [1:0] CMD_STATUS  = 2'd2;

    // configuration register indexes
    localparam logic CFG_NODE_ADDR    = 1'b0;
    localparam logic CFG_LINK_TIMEOUT = 1'b1;

    // frame outcome codes
    localparam logic [2:0] FR_NONE     = 3'd0;
    localparam logic [2:0] FR_MISMATCH = 3'd1;
    localparam logic [2:0] FR_CRC_ERR  = 3'd2;
    localparam logic [2:0] FR_OTHER    = 3'd3;
    localparam logic [2:0] FR_REPLIED  = 3'd4;

    // one queued job: either a single status result or a four-byte reply
    typedef struct packed {
        logic       is_reply;
        logic [2:0] frame_result;
        logic       link_up;
        logic [7:0] reply_byte;
    } t_job;

    // CRC-16 update over one byte, MSB first, no reflection
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/psfr_front.sv
// Front end: takes requests, assembles and checks frames, keeps timer and status, emits jobs.
module psfr_front
    import psfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [TIMEOUT_W-1:0] i_cfg_wdata,
    input  logic                 i_accept,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_rx_byte,
    input  logic [STATUS_W-1:0]  i_status_code,
    output logic                 o_push,
    output t_job                 o_job
);

    logic [NODE_W-1:0]     r_node,    n_node;
    logic [TIMEOUT_W-1:0]  r_timeout, n_timeout;
    logic [1:0]            r_pos,     n_pos;
    logic [7:0]            r_b0,      n_b0;
    logic [7:0]            r_b2,      n_b2;
    logic                  r_pair_ok, n_pair_ok;
    logic [15:0]           r_crc,     n_crc;
    logic [STATUS_W-1:0]   r_status,  n_status;
    logic [TIMER_BITS-1:0] r_ms,      n_ms;
    logic [2:0]            fr;

    always_comb begin
        n_node    = r_node;
        n_timeout = r_timeout;
        n_pos     = r_pos;
        n_b0      = r_b0;
        n_b2      = r_b2;
        n_pair_ok = r_pair_ok;
        n_crc     = r_crc;
        n_status  = r_status;
        n_ms      = r_ms;
        fr        = FR_NONE;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NODE_ADDR:    n_node    = i_cfg_wdata[NODE_W-1:0];
                CFG_LINK_TIMEOUT: n_timeout = i_cfg_wdata;
                default: ;
            endcase
        end

        if (i_accept) begin
            case (i_command)
                CMD_MS_TICK: begin
                    if (r_ms != {TIMER_BITS{1'b1}}) begin
                        n_ms = r_ms + TIMER_BITS'(1);
                    end
                end
                CMD_STATUS: begin
                    n_status = i_status_code;
                end
                CMD_RX_BYTE: begin
                    n_pos = r_pos + 2'd1;
                    case (r_pos)
                        2'd0: begin
                            n_b0  = i_rx_byte;
                            n_crc = crc_byte(CRC_INIT, i_rx_byte);
                        end
                        2'd1: begin
                            n_pair_ok = (i_rx_byte == r_b0);
                            n_crc     = crc_byte(r_crc, i_rx_byte);
                        end
                        2'd2: begin
                            n_b2 = i_rx_byte;
                        end
                        default: begin
                            // fourth byte closes the frame: pair, then CRC, then address
                            if (!r_pair_ok) begin
                                fr = FR_MISMATCH;
                            end else if (r_crc != {r_b2, i_rx_byte}) begin
                                fr = FR_CRC_ERR;
                            end else if (r_b0[7:4] != r_node) begin
                                fr = FR_OTHER;
                            end else begin
                                fr   = FR_REPLIED;
                                n_ms = '0;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign o_push             = i_accept;
    assign o_job.is_reply     = (fr == FR_REPLIED);
    assign o_job.frame_result = fr;
    assign o_job.link_up      = (CMP_W'(n_ms) < CMP_W'(r_timeout));
    assign o_job.reply_byte   = {r_node, r_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node    <= '0;
            r_timeout <= TIMEOUT_RESET;
            r_pos     <= '0;
            r_status  <= '0;
            r_ms      <= '0;
        end else begin
            r_node    <= n_node;
            r_timeout <= n_timeout;
            r_pos     <= n_pos;
            r_status  <= n_status;
            r_ms      <= n_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0      <= n_b0;
        r_b2      <= n_b2;
        r_pair_ok <= n_pair_ok;
        r_crc     <= n_crc;
    end

endmodule

FILE: rtl/core/psfr_queue.sv
// Small job queue between front end and reply sequencer.
module psfr_queue
    import psfr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count,  n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

FILE: rtl/core/psfr_back.sv
// Back end: drains jobs into result beats, sequencing the four reply bytes and their CRC.
module psfr_back
    import psfr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_tx_byte,
    output logic       o_tx_valid,
    output logic       o_last,
    output logic [2:0] o_frame_result,
    output logic       o_link_up
);

    typedef enum logic [3:0] {
        BEAT_ADDR0  = 4'b0001,
        BEAT_ADDR1  = 4'b0010,
        BEAT_CRC_HI = 4'b0100,
        BEAT_CRC_LO = 4'b1000
    } t_beat;

    t_beat       r_beat, n_beat;
    logic [15:0] r_crc,  n_crc;
    logic        r_valid, n_valid;
    logic [7:0]  r_tx,    n_tx;
    logic        r_txv,   n_txv;
    logic        r_last,  n_last;
    logic [2:0]  r_fr,    n_fr;
    logic        r_lu,    n_lu;
    logic        load;

    // output register takes a new beat when empty or being drained
    assign load = !r_valid || i_ready;

    always_comb begin
        n_beat  = r_beat;
        n_crc   = r_crc;
        n_valid = r_valid;
        n_tx    = r_tx;
        n_txv   = r_txv;
        n_last  = r_last;
        n_fr    = r_fr;
        n_lu    = r_lu;
        o_pop   = 1'b0;

        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_fr = i_head.frame_result;
                n_lu = i_head.link_up;
                if (!i_head.is_reply) begin
                    n_tx   = 8'h00;
                    n_txv  = 1'b0;
                    n_last = 1'b1;
                    o_pop  = 1'b1;
                end else begin
                    n_txv  = 1'b1;
                    n_last = 1'b0;
                    case (r_beat)
                        BEAT_ADDR0: begin
                            n_tx   = i_head.reply_byte;
                            n_crc  = crc_byte(CRC_INIT, i_head.reply_byte);
                            n_beat = BEAT_ADDR1;
                        end
                        BEAT_ADDR1: begin
                            n_tx   = i_head.reply_byte;
                            n_crc  = crc_byte(r_crc, i_head.reply_byte);
                            n_beat = BEAT_CRC_HI;
                        end
                        BEAT_CRC_HI: begin
                            n_tx   = r_crc[15:8];
                            n_beat = BEAT_CRC_LO;
                        end
                        BEAT_CRC_LO: begin
                            n_tx   = r_crc[7:0];
                            n_last = 1'b1;
                            o_pop  = 1'b1;
                            n_beat = BEAT_ADDR0;
                        end
                        default: begin
                            n_beat = BEAT_ADDR0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat  <= BEAT_ADDR0;
            r_valid <= 1'b0;
        end else begin
            r_beat  <= n_beat;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc  <= n_crc;
        r_tx   <= n_tx;
        r_txv  <= n_txv;
        r_last <= n_last;
        r_fr   <= n_fr;
        r_lu   <= n_lu;
    end

    assign o_valid        = r_valid;
    assign o_tx_byte      = r_tx;
    assign o_tx_valid     = r_txv;
    assign o_last         = r_last;
    assign o_frame_result = r_fr;
    assign o_link_up      = r_lu;

endmodule

FILE: rtl/core/polled_slave_frame_responder.sv
// Polled serial-bus slave: frame check, link timer and reply generation.
//
// Slave stream carries requests: tuser = command (bus byte, ms tick, new status),
// tdata = rx_byte and status_code. Master stream carries results: one per request,
// or four for a good poll addressed to this node (address/status byte twice, then
// CRC-16 high and low), with tlast on the final one.
// Configuration: i_cfg_we writes node address (index 0) or link timeout (index 1);
// write only while the block is idle.
// Path: an accepted request is held in the job queue, then in the output register.
// Throughput: one request per cycle unless the job queue is full; a reply occupies
// the output for four beats, as the single output register drains one byte a cycle when
// ready. A four-entry job queue lets the front keep taking requests as replies drain.
// Stall: tready on the slave side drops only when the job queue is full; master
// payload holds while i_m_axis_tready is low.
// Reset (synchronous, active low): byte position, status and timer clear, node
// address 0, timeout 60000 ms, queue and output empty; link reads up.
module polled_slave_frame_responder
    import psfr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [TIMEOUT_W-1:0] i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [15:0]          i_s_axis_tdata,   // [7:0] rx_byte, [11:8] status_code
    input  logic [1:0]           i_s_axis_tuser,   // [1:0] command
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [15:0]          o_m_axis_tdata,   // [7:0] tx_byte, [8] link_up
    output logic [3:0]           o_m_axis_tuser,   // [0] tx_valid, [3:1] frame_result
    output logic                 o_m_axis_tlast
);

    logic       accept;
    logic       push;
    t_job       push_job;
    logic       full;
    logic       pop;
    t_job       head;
    logic       empty;
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       last;
    logic [2:0] frame_result;
    logic       link_up;

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;

    psfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (accept),
        .i_command     (i_s_axis_tuser),
        .i_rx_byte     (i_s_axis_tdata[7:0]),
        .i_status_code (i_s_axis_tdata[11:8]),
        .o_push        (push),
        .o_job         (push_job)
    );

    psfr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_job (push_job),
        .o_full     (full),
        .i_pop      (pop),
        .o_head     (head),
        .o_empty    (empty)
    );

    psfr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_tx_byte      (tx_byte),
        .o_tx_valid     (tx_valid),
        .o_last         (last),
        .o_frame_result (frame_result),
        .o_link_up      (link_up)
    );

    assign o_m_axis_tdata = {7'd0, link_up, tx_byte};
    assign o_m_axis_tuser = {frame_result, tx_valid};
    assign o_m_axis_tlast = last;

endmodule

FILE: rtl/core/psfr_checker.sv
// Port-level checker for the polled slave frame responder, bound to the top level.
module psfr_checker
    import psfr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic                 i_cfg_idx,
    input logic [TIMEOUT_W-1:0] i_cfg_wdata,
    input logic                 i_s_axis_tvalid,
    input logic                 o_s_axis_tready,
    input logic [15:0]          i_s_axis_tdata,
    input logic [1:0]           i_s_axis_tuser,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [15:0]          o_m_axis_tdata,
    input logic [3:0]           o_m_axis_tuser,
    input logic                 o_m_axis_tlast
);

    // output empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // a reply byte only ever belongs to a replied frame
    a_reply_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tuser[3:1] == FR_REPLIED)
        else $error("reply byte without replied code");

    // non-reply results are single, zero-byte beats
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tlast && o_m_axis_tdata[7:0] == 8'h00
            && o_m_axis_tuser[3:1] != FR_REPLIED)
        else $error("malformed non-reply result");

    // the second reply beat repeats the first address/status byte
    a_addr_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser[0] && !o_m_axis_tlast
        && !($past(o_m_axis_tvalid) && $past(o_m_axis_tuser[0])
             && !$past(o_m_axis_tlast))
        ##1 o_m_axis_tvalid |-> o_m_axis_tuser[0] && !o_m_axis_tlast
            && o_m_axis_tdata[7:0] == $past(o_m_axis_tdata[7:0]))
        else $error("reply address byte not repeated");

endmodule

bind polled_slave_frame_responder psfr_checker u_psfr_checker (.*);

FILE: dv/tb_polled_slave_frame_responder.sv
// Self-checking testbench for the polled slave frame responder: framed polls, ticks, status.
module tb_polled_slave_frame_responder;
    import psfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 200_000;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [7:0]          rx;
        logic [STATUS_W-1:0] status;
    } t_bus_request;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_valid;
        logic       last;
        logic [2:0] frame_result;
        logic       link_up;
    } t_reply_beat;

    // Tracks node state and holds the reply beats still owed by the block.
    class poll_reply_board;
        logic [NODE_W-1:0]     node_addr;
        logic [TIMEOUT_W-1:0]  timeout_ms;
        logic [1:0]            byte_pos;
        logic [7:0]            frame_bytes [3];
        logic [STATUS_W-1:0]   status_latch;
        logic [TIMER_BITS-1:0] ms_count;
        t_reply_beat           owed_beats [$];
        int                    fail_count;

        function new();
            node_addr    = '0;
            timeout_ms   = TIMEOUT_RESET;
            byte_pos     = '0;
            status_latch = '0;
            ms_count     = '0;
            fail_count   = 0;
        endfunction

        static function logic [15:0] crc_pair(logic [7:0] a, logic [7:0] b);
            logic [15:0] c;
            logic [7:0]  d [2];
            d[0] = a;
            d[1] = b;
            c = 16'hFFFF;
            for (int i = 0; i < 2; i++) begin
                c = c ^ {d[i], 8'h00};
                for (int k = 0; k < 8; k++) begin
                    c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
                end
            end
            return c;
        endfunction

        function void apply_reg(logic idx, logic [TIMEOUT_W-1:0] val);
            if (idx == CFG_NODE_ADDR) begin
                node_addr = val[NODE_W-1:0];
            end else begin
                timeout_ms = val;
            end
        endfunction

        function void owe(logic [7:0] tx, logic vld, logic lst, logic [2:0] res);
            t_reply_beat b;
            b.tx_byte      = tx;
            b.tx_valid     = vld;
            b.last         = lst;
            b.frame_result = res;
            // link state is taken after the request has updated the timer
            b.link_up      = (TIMEOUT_W'(ms_count) < timeout_ms);
            owed_beats.push_back(b);
        endfunction

        function void note_request(t_bus_request r);
            logic [7:0]  reply;
            logic [15:0] crc;
            case (r.cmd)
                CMD_MS_TICK: begin
                    if (ms_count != '1) ms_count = ms_count + 1'b1;
                    owe(8'h00, 1'b0, 1'b1, FR_NONE);
                end
                CMD_STATUS: begin
                    status_latch = r.status;
                    owe(8'h00, 1'b0, 1'b1, FR_NONE);
                end
                CMD_RX_BYTE: begin
                    if (byte_pos != 2'd3) begin
                        frame_bytes[byte_pos] = r.rx;
                        byte_pos = byte_pos + 1'b1;
                        owe(8'h00, 1'b0, 1'b1, FR_NONE);
                    end else begin
                        byte_pos = '0;
                        // pair check first, then crc, then address
                        if (frame_bytes[0] != frame_bytes[1]) begin
                            owe(8'h00, 1'b0, 1'b1, FR_MISMATCH);
                        end else if (crc_pair(frame_bytes[0], frame_bytes[1])
                                     != {frame_bytes[2], r.rx}) begin
                            owe(8'h00, 1'b0, 1'b1, FR_CRC_ERR);
                        end else if (frame_bytes[0][7:4] != node_addr) begin
                            owe(8'h00, 1'b0, 1'b1, FR_OTHER);
                        end else begin
                            ms_count = '0;
                            reply = {node_addr, status_latch};
                            crc   = crc_pair(reply, reply);
                            owe(reply,     1'b1, 1'b0, FR_REPLIED);
                            owe(reply,     1'b1, 1'b0, FR_REPLIED);
                            owe(crc[15:8], 1'b1, 1'b0, FR_REPLIED);
                            owe(crc[7:0],  1'b1, 1'b1, FR_REPLIED);
                        end
                    end
                end
                default: owe(8'h00, 1'b0, 1'b1, FR_NONE);
            endcase
        endfunction

        function void check_result(t_reply_beat got);
            t_reply_beat exp;
            if (owed_beats.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $write("unexpected result: tx %02h valid %0d last %0d",
                           got.tx_byte, got.tx_valid, got.last);
                    $display(" result %0d link %0d", got.frame_result, got.link_up);
                end
                return;
            end
            exp = owed_beats.pop_front();
            if (got.tx_byte != exp.tx_byte || got.tx_valid != exp.tx_valid ||
                got.last != exp.last || got.frame_result != exp.frame_result ||
                got.link_up != exp.link_up) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $write("mismatch: exp tx %02h valid %0d last %0d result %0d link %0d",
                           exp.tx_byte, exp.tx_valid, exp.last, exp.frame_result,
                           exp.link_up);
                    $display(" / got tx %02h valid %0d last %0d result %0d link %0d",
                             got.tx_byte, got.tx_valid, got.last,
                             got.frame_result, got.link_up);
                end
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_idx = 1'b0;
    logic [TIMEOUT_W-1:0] cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [15:0]          s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 o_m_axis_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          o_m_axis_tdata;
    logic [3:0]           o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    poll_reply_board board;
    t_bus_request    req_q [$];
    t_reply_beat     seen_beat;
    int              send_idle_pct = 24;
    int              recv_idle_pct = 76;
    int              items_pushed = 0;
    logic [1:0]      gen_pos = '0;   // byte position as seen by the stimulus
    int              cycle_count = 0;

    polled_slave_frame_responder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** polled_slave_frame_responder: FAILED **");
            $finish;
        end
    end

    // request driver: the presented request is always the head of req_q
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                board.note_request(req_q.pop_front());
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'h0, req_q[0].status, req_q[0].rx};
                    s_tuser  <= req_q[0].cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                seen_beat.tx_byte      = o_m_axis_tdata[7:0];
                seen_beat.link_up      = o_m_axis_tdata[8];
                seen_beat.tx_valid     = o_m_axis_tuser[0];
                seen_beat.frame_result = o_m_axis_tuser[3:1];
                seen_beat.last         = o_m_axis_tlast;
                board.check_result(seen_beat);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_req(input logic [1:0] cmd, input logic [7:0] rx,
                            input logic [STATUS_W-1:0] st);
        t_bus_request r;
        r.cmd    = cmd;
        r.rx     = rx;
        r.status = st;
        while (req_q.size() >= 16) @(posedge i_clk);
        req_q.push_back(r);
        items_pushed++;
        if (cmd == CMD_RX_BYTE) gen_pos = gen_pos + 1'b1;
    endtask

    task automatic push_side_cmd();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) begin
            push_req(CMD_MS_TICK, 8'($urandom_range(255)), 4'($urandom_range(15)));
        end else if (pick < 8) begin
            push_req(CMD_STATUS, 8'($urandom_range(255)), 4'($urandom_range(15)));
        end else begin
            push_req(CMD_UNUSED, 8'($urandom_range(255)), 4'($urandom_range(15)));
        end
    endtask

    task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] c1, input logic [7:0] c0);
        logic [7:0] fb [4];
        fb[0] = b0;
        fb[1] = b1;
        fb[2] = c1;
        fb[3] = c0;
        // realign after stray bytes so the frame lands on a boundary
        while (gen_pos != 2'd0)
            push_req(CMD_RX_BYTE, 8'($urandom_range(255)), 4'($urandom_range(15)));
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(99) < 12) push_side_cmd();
            push_req(CMD_RX_BYTE, fb[i], 4'($urandom_range(15)));
        end
    endtask

    task automatic send_poll(input logic [7:0] b);
        logic [15:0] crc;
        crc = poll_reply_board::crc_pair(b, b);
        send_frame(b, b, crc[15:8], crc[7:0]);
    endtask

    task automatic gen_traffic(input int n);
        int          start;
        int          pick;
        logic [7:0]  b;
        logic [15:0] crc;
        start = items_pushed;
        while (items_pushed - start < n) begin
            pick = $urandom_range(99);
            b    = 8'($urandom_range(255));
            if (pick < 45) begin
                send_poll({board.node_addr, b[3:0]});
            end else if (pick < 55) begin
                send_poll(b);
            end else if (pick < 62) begin
                send_frame(b, b ^ (8'h01 << $urandom_range(7)),
                           8'($urandom_range(255)), 8'($urandom_range(255)));
            end else if (pick < 70) begin
                b   = {board.node_addr, b[3:0]};
                crc = poll_reply_board::crc_pair(b, b) ^ (16'h0001 << $urandom_range(15));
                send_frame(b, b, crc[15:8], crc[7:0]);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4))
                    push_req(CMD_MS_TICK, 8'($urandom_range(255)), 4'($urandom_range(15)));
            end else if (pick < 97) begin
                push_side_cmd();
            end else begin
                push_req(CMD_RX_BYTE, b, 4'($urandom_range(15)));
            end
        end
    endtask

    task automatic wait_drained();
        while (req_q.size() != 0 || board.owed_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic idx, input logic [TIMEOUT_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        board.apply_reg(idx, val);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct,
                             input logic [NODE_W-1:0] node,
                             input logic [TIMEOUT_W-1:0] tmo, input int n);
        wait_drained();
        program_reg(CFG_NODE_ADDR, TIMEOUT_W'(node));
        program_reg(CFG_LINK_TIMEOUT, tmo);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        gen_traffic(n);
    endtask

    initial begin
        logic [15:0] crc;
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests at reset configuration: node 0, 60000 ms
        send_poll(8'h00);
        push_req(CMD_STATUS, 8'h00, 4'hF);
        push_req(CMD_UNUSED, 8'hFF, 4'h0);
        send_frame(8'h00, 8'hFF, 8'h12, 8'h34);          // pair mismatch wins
        crc = poll_reply_board::crc_pair(8'hF5, 8'hF5) ^ 16'h0100;
        send_frame(8'hF5, 8'hF5, crc[15:8], crc[7:0]);   // crc error before address
        send_poll(8'hFF);                                // other node
        send_poll(8'h0A);
        push_req(CMD_MS_TICK, 8'h00, 4'h0);
        push_req(CMD_MS_TICK, 8'hFF, 4'hF);
        push_req(CMD_STATUS, 8'hFF, 4'h0);

        run_phase(24, 76, 4'hF, TIMEOUT_W'(1), 50);
        run_phase(76, 24, 4'($urandom_range(15)), '0, 50);   // link always down
        run_phase(76, 24, 4'h7, TIMEOUT_W'(5), 60);
        run_phase(0, 0, 4'h0, TIMEOUT_W'($urandom_range(1048575, 1)), 60);

        // ticks with the widest timeout
        wait_drained();
        program_reg(CFG_NODE_ADDR, TIMEOUT_W'(3));
        program_reg(CFG_LINK_TIMEOUT, '1);
        send_poll(8'h3C);
        repeat (8)
            push_req(CMD_MS_TICK, 8'($urandom_range(255)), 4'($urandom_range(15)));
        push_req(CMD_STATUS, 8'h5A, 4'h9);
        send_poll(8'h30);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (board.fail_count == 0) begin
            $display("** polled_slave_frame_responder: PASSED **");
        end else begin
            $display("** polled_slave_frame_responder: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/psfr_pkg.sv
rtl/core/psfr_front.sv
rtl/core/psfr_queue.sv
rtl/core/psfr_back.sv
rtl/core/polled_slave_frame_responder.sv
rtl/core/psfr_checker.sv
dv/tb_polled_slave_frame_responder.sv
